FILE: sv/bdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdw_pkg;

  // Work RAM size and data-port pointer width
  localparam int WRAM_BYTES_DEF = 131072;
  localparam int PTR_W          = 17;
  localparam int ADDR_W         = 24;
  localparam int BYTE_W         = 8;

  // Address map
  localparam logic [7:0] PAGE_WRAM_END = 8'h20;  // system pages below this mirror work RAM
  localparam logic [7:0] PAGE_BBUS     = 8'h21;
  localparam logic [7:0] PAGE_CPU_LO   = 8'h42;
  localparam logic [7:0] PAGE_CPU_HI   = 8'h43;
  localparam logic [6:0] BANK_WRAM_HI  = 7'h3F;  // banks 0x7E/0x7F
  localparam logic [3:0] BANK_SRAM_HI  = 4'hF;   // banks 0xF0-0xFF take writes below page 0x80

  localparam logic [7:0] OFF_PICT_LAST = 8'h3F;
  localparam logic [7:0] OFF_APU_LAST  = 8'h43;
  localparam logic [7:0] OFF_WM_DATA   = 8'h80;
  localparam logic [7:0] OFF_WM_ADDL   = 8'h81;
  localparam logic [7:0] OFF_WM_ADDM   = 8'h82;
  localparam logic [7:0] OFF_WM_ADDH   = 8'h83;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_WRAM,
    TGT_PICTURE,
    TGT_AUDIO,
    TGT_CPU,
    TGT_CART
  } tgt_e;

endpackage

`default_nettype wire

FILE: sv/bdw_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdw_req_if
  import bdw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] bus_address;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, output func, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input func, input bus_address, input write_byte,
                  output ready);
endinterface

interface bdw_rsp_if
  import bdw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        target;
  logic [ADDR_W-1:0] device_address;
  logic              device_write;
  logic [BYTE_W-1:0] device_data;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, output target, output device_address, output device_write,
                  output device_data, output read_byte, input ready);
  modport sink   (input valid, input target, input device_address, input device_write,
                  input device_data, input read_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/bus_decoder_with_wram_port.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                                   | Beat
// req_i   | in  | func, bus_address, write_byte                             | one bus access
// rsp_o   | out | target, device_address, device_write, device_data,        | one decode result
//         |     | read_byte                                                 |
//
// One access per cycle, sustained while rsp_o.ready is high and no clearing sweep runs. A result
// passes decode and work RAM access in the accept cycle, the read data register and then
// the output register. The single-port work RAM (one access per cycle) sets that rate.
// After reset the RAM is swept to zero, one byte a cycle, with req_i.ready low until every
// byte is clear. A stalled rsp_o holds its beat; a second result waits in the middle stage;
// outside the sweep, req_i.ready drops only when both are full and rsp_o.ready is low.

module bus_decoder_with_wram_port
  import bdw_pkg::*;
#(
  parameter int WORK_RAM_BYTES = WRAM_BYTES_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  bdw_req_if.sink   req_i,
  bdw_rsp_if.source rsp_o
);

  localparam int AW      = $clog2(WORK_RAM_BYTES);
  localparam int ModTop  = PTR_W - AW;        // highest shift of the modulo reduction
  localparam int RemW    = PTR_W + ModTop + 1;
  localparam logic [AW-1:0] WramLast = AW'(WORK_RAM_BYTES - 1);

  // Index modulo the RAM size: restoring compare-subtract, one step per shift from ModTop down to 0
  function automatic logic [AW-1:0] wram_slot(input logic [PTR_W-1:0] a);
    logic [RemW-1:0] rem;
    rem = RemW'(a);
    for (int k = ModTop; k >= 0; k--) begin
      if (rem >= (RemW'(WORK_RAM_BYTES) << k)) begin
        rem = rem - (RemW'(WORK_RAM_BYTES) << k);
      end
    end
    return rem[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic             clr_q;      // clearing sweep running
  logic [AW-1:0]    clr_cnt_q;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             s1_v_q, s2_v_q;

  logic accept, s2_free, s1_adv;

  assign s2_free     = !s2_v_q || rsp_o.ready;
  assign s1_adv      = s1_v_q && s2_free;
  assign req_i.ready = !clr_q && (!s1_v_q || s2_free);
  assign accept      = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic [7:0]       bank, page, off;
  tgt_e             tgt;
  logic             ram_en;
  logic [PTR_W-1:0] ram_a;
  logic             ext;

  assign bank = req_i.bus_address[23:16];
  assign page = req_i.bus_address[15:8];
  assign off  = req_i.bus_address[7:0];

  always_comb begin
    tgt    = TGT_NONE;
    ram_en = 1'b0;
    ram_a  = '0;
    ptr_d  = ptr_q;
    priority if (!bank[6]) begin
      // System banks 0x00-0x3F and 0x80-0xBF
      priority if (page < PAGE_WRAM_END) begin
        tgt    = TGT_WRAM;
        ram_en = 1'b1;
        ram_a  = PTR_W'(req_i.bus_address[12:0]);
      end else if (page == PAGE_BBUS) begin
        priority if (off <= OFF_PICT_LAST) begin
          tgt = TGT_PICTURE;
        end else if (off <= OFF_APU_LAST) begin
          tgt = TGT_AUDIO;
        end else if (off == OFF_WM_DATA) begin
          tgt    = TGT_WRAM;
          ram_en = 1'b1;
          ram_a  = ptr_q;
          ptr_d  = ptr_q + 1'b1;  // wraps at 17 bits
        end else if (req_i.func && off == OFF_WM_ADDL) begin
          tgt   = TGT_WRAM;
          ptr_d = {ptr_q[16:8], req_i.write_byte};
        end else if (req_i.func && off == OFF_WM_ADDM) begin
          tgt   = TGT_WRAM;
          ptr_d = {ptr_q[16], req_i.write_byte, ptr_q[7:0]};
        end else if (req_i.func && off == OFF_WM_ADDH) begin
          tgt   = TGT_WRAM;
          ptr_d = {req_i.write_byte[0], ptr_q[15:0]};
        end else begin
          tgt = TGT_NONE;
        end
      end else if (page == PAGE_CPU_LO || page == PAGE_CPU_HI) begin
        tgt = TGT_CPU;
      end else if (page[7] && !req_i.func) begin
        tgt = TGT_CART;
      end else begin
        tgt = TGT_NONE;  // joypad page and other holes
      end
    end else if (!bank[7]) begin
      // Banks 0x40-0x7F
      priority if (bank[7:1] == BANK_WRAM_HI) begin
        tgt    = TGT_WRAM;
        ram_en = 1'b1;
        ram_a  = {bank[0], req_i.bus_address[15:0]};
      end else if (!req_i.func || !page[7]) begin
        tgt = TGT_CART;
      end else begin
        tgt = TGT_NONE;
      end
    end else if (!req_i.func || (bank[7:4] == BANK_SRAM_HI && !page[7])) begin
      tgt = TGT_CART;
    end else begin
      tgt = TGT_NONE;
    end
  end

  assign ext = (tgt == TGT_PICTURE) || (tgt == TGT_AUDIO) || (tgt == TGT_CPU) ||
               (tgt == TGT_CART);

  // ---------------------------------------------------------------------------
  // Work RAM: single port, registered read, swept to zero after reset
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] wram [WORK_RAM_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_a;
  logic [BYTE_W-1:0] mem_wd;

  assign mem_we = clr_q || (accept && ram_en && req_i.func);
  assign mem_re = accept && ram_en && !req_i.func;
  assign mem_a  = clr_q ? clr_cnt_q : wram_slot(ram_a);
  assign mem_wd = clr_q ? '0 : req_i.write_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wram[mem_a] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= wram[mem_a];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      ptr_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == WramLast) begin
          clr_q <= 1'b0;
        end
      end
      if (accept) begin
        ptr_q <= ptr_d;
      end
      priority if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      priority if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: middle stage (beside rdata_q) and output register
  // ---------------------------------------------------------------------------
  tgt_e              s1_tgt_q, s2_tgt_q;
  logic [ADDR_W-1:0] s1_addr_q, s2_addr_q;
  logic              s1_wr_q, s2_wr_q;
  logic [BYTE_W-1:0] s1_data_q, s2_data_q;
  logic              s1_rd_q;
  logic [BYTE_W-1:0] s2_rbyte_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tgt_q  <= tgt;
      s1_addr_q <= ext ? req_i.bus_address : '0;
      s1_wr_q   <= ext && req_i.func;
      s1_data_q <= (ext && req_i.func) ? req_i.write_byte : '0;
      s1_rd_q   <= mem_re;
    end
    if (s1_adv) begin
      s2_tgt_q   <= s1_tgt_q;
      s2_addr_q  <= s1_addr_q;
      s2_wr_q    <= s1_wr_q;
      s2_data_q  <= s1_data_q;
      s2_rbyte_q <= s1_rd_q ? rdata_q : '0;
    end
  end

  assign rsp_o.valid          = s2_v_q;
  assign rsp_o.target         = s2_tgt_q;
  assign rsp_o.device_address = s2_addr_q;
  assign rsp_o.device_write   = s2_wr_q;
  assign rsp_o.device_data    = s2_data_q;
  assign rsp_o.read_byte      = s2_rbyte_q;

endmodule

`default_nettype wire
